// ===== hw/rtl/imm_pkg.sv =====
// shared types, constants and helpers of the integer matrix multiply block
// no dependencies; every other file but imm_ram imports this package
package imm_pkg;

	// store geometry
	localparam int MAX_DIM = 8;
	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int ADDR_W  = 2 * IDX_W;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int DATA_W  = 32;
	localparam int DIM_W   = 4;
	localparam int FUNC_W  = 2;
	localparam int CFG_IDX_W = 2;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD_LEFT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_RIGHT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE    = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ROWS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLS = 2'd2;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_ISSUE,
		SEQ_DRAIN
	} seq_state_t;

	// tag that travels with each multiply-accumulate step
	typedef struct packed {
		logic             valid;
		logic             first;
		logic             last_k;
		logic             last_elem;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} mac_tag_t;

	// store write request
	typedef struct packed {
		logic              we_left;
		logic              we_right;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} ram_wr_t;

	// saturate a dimension register to 1..MAX_DIM and return it minus one
	function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] v);
		logic [IDX_W-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = IDX_W'(MAX_DIM - 1);
		end else begin
			r = IDX_W'(v - DIM_W'(1));
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/imm_if.sv =====
// channel interfaces: command stream, result stream, configuration writes
// depends on imm_pkg
interface imm_in_if;
	import imm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [DATA_W-1:0] elem_value;
	modport source (output valid, func, row_index, col_index, elem_value, input ready);
	modport sink (input valid, func, row_index, col_index, elem_value, output ready);
endinterface

interface imm_out_if;
	import imm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic signed [DATA_W-1:0] product_value;
	logic                     last;
	modport source (output valid, out_row, out_col, product_value, last, input ready);
	modport sink (input valid, out_row, out_col, product_value, last, output ready);
endinterface

interface imm_cfg_if;
	import imm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/imm_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module imm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/imm_seq.sv =====
// sequencer: command intake, dimension registers, store writes and read address walk
// depends on imm_pkg and imm_if
module imm_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	imm_in_if.sink                cmd,
	imm_cfg_if.sink               cfg,
	input  logic                  busy,
	output imm_pkg::ram_wr_t      wr,
	output logic [imm_pkg::ADDR_W-1:0] left_raddr,
	output logic [imm_pkg::ADDR_W-1:0] right_raddr,
	output imm_pkg::mac_tag_t     tag
);
	import imm_pkg::*;

	seq_state_t state_q, state_d;
	logic [DIM_W-1:0] left_rows_q, inner_dim_q, right_cols_q;
	logic [IDX_W-1:0] r_q, c_q, k_q;
	logic             done_q;
	logic [IDX_W-1:0] nr_last, nk_last, nc_last;
	logic             cmd_xfer, start, k_end, elem_end;

	assign nr_last  = dim_last(left_rows_q);
	assign nk_last  = dim_last(inner_dim_q);
	assign nc_last  = dim_last(right_cols_q);
	assign cmd_xfer = cmd.valid && cmd.ready;
	assign start    = cmd_xfer && (cmd.func == FUNC_COMPUTE);
	assign k_end    = (k_q == nk_last);
	assign elem_end = (r_q == nr_last) && (c_q == nc_last);

	// configuration registers, always writable
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q  <= DIM_W'(MAX_DIM);
			inner_dim_q  <= DIM_W'(MAX_DIM);
			right_cols_q <= DIM_W'(MAX_DIM);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LEFT_ROWS:  left_rows_q  <= cfg.data;
				CFG_INNER_DIM:  inner_dim_q  <= cfg.data;
				CFG_RIGHT_COLS: right_cols_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE:  if (start) state_d = SEQ_ISSUE;
			SEQ_ISSUE: if (k_end) state_d = SEQ_DRAIN;
			SEQ_DRAIN: if (!busy) state_d = done_q ? SEQ_IDLE : SEQ_ISSUE;
			default:   state_d = SEQ_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.ready     = (state_q == SEQ_IDLE);
		tag.valid     = (state_q == SEQ_ISSUE);
		tag.first     = (k_q == '0);
		tag.last_k    = k_end;
		tag.last_elem = elem_end;
		tag.row       = r_q;
		tag.col       = c_q;
	end

	// store writes come straight from load transfers
	always_comb begin
		wr.we_left  = cmd_xfer && (cmd.func == FUNC_LOAD_LEFT);
		wr.we_right = cmd_xfer && (cmd.func == FUNC_LOAD_RIGHT);
		wr.addr     = {cmd.row_index, cmd.col_index};
		wr.data     = cmd.elem_value;
	end

	// left walks along row r, right walks down column c
	assign left_raddr  = {r_q, k_q};
	assign right_raddr = {k_q, c_q};

	// state and index counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				r_q    <= '0;
				c_q    <= '0;
				k_q    <= '0;
				done_q <= 1'b0;
			end else if (state_q == SEQ_ISSUE) begin
				if (k_end) begin
					k_q <= '0;
					if (elem_end) begin
						done_q <= 1'b1;
					end
					if (c_q == nc_last) begin
						c_q <= '0;
						r_q <= r_q + IDX_W'(1);
					end else begin
						c_q <= c_q + IDX_W'(1);
					end
				end else begin
					k_q <= k_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

// ===== hw/rtl/imm_mac.sv =====
// multiply-accumulate pipeline and result register
// depends on imm_pkg and imm_if
module imm_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  imm_pkg::mac_tag_t          tag,
	input  logic [imm_pkg::DATA_W-1:0] left_data,
	input  logic [imm_pkg::DATA_W-1:0] right_data,
	output logic                       busy,
	imm_out_if.source                  res
);
	import imm_pkg::*;

	mac_tag_t          tag_s1, tag_s2;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] sum;
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_row_q, out_col_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_last_q;

	assign busy = tag_s1.valid || tag_s2.valid || out_valid_q;

	// tag follows the store read latency, then the multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
		end
	end

	// low word of the product, same for signed and unsigned operands
	always_ff @(posedge clk) begin
		prod_s2 <= DATA_W'(left_data * right_data);
	end

	// wrapping accumulate
	assign sum = (tag_s2.first ? '0 : acc_q) + prod_s2;

	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			acc_q <= sum;
		end
	end

	// result register, loaded only when empty since the sequencer waits for it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tag_s2.valid && tag_s2.last_k) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s2.valid && tag_s2.last_k) begin
			out_row_q   <= tag_s2.row;
			out_col_q   <= tag_s2.col;
			out_value_q <= sum;
			out_last_q  <= tag_s2.last_elem;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.out_row       = out_row_q;
	assign res.out_col       = out_col_q;
	assign res.product_value = out_value_q;
	assign res.last          = out_last_q;

endmodule

// ===== hw/rtl/integer_matrix_multiply.sv =====
// Integer matrix multiply engine. Load transfers (func load left / load right) write one
// element into the left or right store. A compute transfer emits every product element in
// row-major order, the final one flagged with last. The block takes no new command while a
// compute run is in progress. Each product element takes inner_dim store reads, one
// multiply-accumulate per cycle limited by the single read port of each store; the
// sequencer then waits for the pipeline to drain and the result to be taken before the next
// element. Dimension registers saturate to 1..8 and are written through the cfg channel,
// which is always ready. Stores are not cleared at reset; read only elements you loaded.
// depends on imm_pkg, imm_if, imm_ram, imm_seq, imm_mac
module integer_matrix_multiply (
	input  logic      clk,
	input  logic      arst_n,
	imm_in_if.sink    cmd,
	imm_cfg_if.sink   cfg,
	imm_out_if.source res
);
	import imm_pkg::*;

	ram_wr_t           wr;
	mac_tag_t          tag;
	logic [ADDR_W-1:0] left_raddr, right_raddr;
	logic [DATA_W-1:0] left_data, right_data;
	logic              busy;

	// command intake and address walk
	imm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.busy        (busy),
		.wr          (wr),
		.left_raddr  (left_raddr),
		.right_raddr (right_raddr),
		.tag         (tag)
	);

	// element stores
	imm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_left_ram (
		.clk   (clk),
		.we    (wr.we_left),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (left_raddr),
		.rdata (left_data)
	);

	imm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_right_ram (
		.clk   (clk),
		.we    (wr.we_right),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (right_raddr),
		.rdata (right_data)
	);

	// datapath
	imm_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag        (tag),
		.left_data  (left_data),
		.right_data (right_data),
		.busy       (busy),
		.res        (res)
	);

endmodule

// ===== hw/rtl/imm_checker.sv =====
// port-level checks of the integer matrix multiply block, bound to the top level
// depends on imm_pkg
module imm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic [imm_pkg::FUNC_W-1:0] cmd_func,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [imm_pkg::IDX_W-1:0]  res_row,
	input logic [imm_pkg::IDX_W-1:0]  res_col,
	input logic [imm_pkg::DATA_W-1:0] res_value,
	input logic                       res_last
);
	import imm_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_row) && $stable(res_col)
			&& $stable(res_value) && $stable(res_last))
		else $error("stalled result changed");

	// no command is taken while a result waits
	a_no_cmd_with_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !cmd_ready)
		else $error("command ready while result pending");

	// a load or unused command produces no result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_func != FUNC_COMPUTE |=> !res_valid)
		else $error("result after a non-compute command");

	// a compute run blocks further commands
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_func == FUNC_COMPUTE |=> !cmd_ready)
		else $error("command ready right after compute start");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_func  (cmd.func),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_row   (res.out_row),
	.res_col   (res.out_col),
	.res_value (res.product_value),
	.res_last  (res.last)
);
